### rtl/tif_pkg.sv
// tif_pkg: shared constants and the result struct of the telnet iac filter
// no dependencies; used by tif_if.sv, tif_parse.sv, telnet_iac_filter.sv and the bench
package tif_pkg;

  localparam int BUF_CAPACITY_DEF = 1024;
  localparam int PREFIX_LEN_DEF   = 4;

  localparam int STORED_COUNT_W = 11;
  localparam int PREFIX_COUNT_W = 3;

  localparam logic [7:0] CODE_IAC  = 8'd255;
  localparam logic [7:0] CODE_DONT = 8'd254;
  localparam logic [7:0] CODE_DO   = 8'd253;
  localparam logic [7:0] CODE_WONT = 8'd252;
  localparam logic [7:0] CODE_WILL = 8'd251;

  localparam logic [1:0] PHASE_DATA = 2'd0;
  localparam logic [1:0] PHASE_CMD  = 2'd1;
  localparam logic [1:0] PHASE_OPT  = 2'd2;

  localparam logic [1:0] VERB_QUIET = 2'd0;
  localparam logic [1:0] VERB_WILL  = 2'd1;
  localparam logic [1:0] VERB_DO    = 2'd2;

  localparam logic REPLY_DONT = 1'b0;
  localparam logic REPLY_WONT = 1'b1;

  typedef struct packed {
    logic                      data_valid;
    logic [7:0]                data_byte;
    logic                      in_prefix;
    logic                      neg_valid;
    logic                      neg_reply;
    logic [7:0]                neg_option;
    logic                      line_done;
    logic [STORED_COUNT_W-1:0] stored_count;
    logic [PREFIX_COUNT_W-1:0] prefix_count;
  } res_t;

endpackage

### rtl/tif_if.sv
// tif_in_if / tif_out_if: valid-ready channels of the telnet iac filter
// depends on tif_pkg for the count widths
interface tif_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_line;

  modport source (output valid, output rx_byte, output end_of_line, input ready);
  modport sink   (input valid, input rx_byte, input end_of_line, output ready);
endinterface

interface tif_out_if;
  logic                               valid;
  logic                               ready;
  logic                               data_valid;
  logic [7:0]                         data_byte;
  logic                               in_prefix;
  logic                               neg_valid;
  logic                               neg_reply;
  logic [7:0]                         neg_option;
  logic                               line_done;
  logic [tif_pkg::STORED_COUNT_W-1:0] stored_count;
  logic [tif_pkg::PREFIX_COUNT_W-1:0] prefix_count;

  modport source (output valid, output data_valid, output data_byte, output in_prefix,
                  output neg_valid, output neg_reply, output neg_option, output line_done,
                  output stored_count, output prefix_count, input ready);
  modport sink   (input valid, input data_valid, input data_byte, input in_prefix,
                  input neg_valid, input neg_reply, input neg_option, input line_done,
                  input stored_count, input prefix_count, output ready);
endinterface

### rtl/tif_parse.sv
// tif_parse: command parser state and per-line counters, forms one result per byte
// depends on tif_pkg
module tif_parse #(
  parameter int BUF_CAPACITY = tif_pkg::BUF_CAPACITY_DEF,
  parameter int PREFIX_LEN   = tif_pkg::PREFIX_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [7:0]    rx_byte,
  input  logic          end_of_line,
  output tif_pkg::res_t res
);

  localparam int SW = $clog2(BUF_CAPACITY + 1);
  localparam int PW = $clog2(PREFIX_LEN + 1);
  localparam int SCW = tif_pkg::STORED_COUNT_W;
  localparam int PCW = tif_pkg::PREFIX_COUNT_W;

  logic [1:0]    phase_r, phase_nxt, phase_upd;
  logic [1:0]    verb_r, verb_nxt, verb_upd;
  logic [SW-1:0] stored_r, stored_nxt, stored_upd;
  logic [PW-1:0] prefix_r, prefix_nxt, prefix_upd;

  logic [SW+SCW-1:0] stored_ext;
  logic [PW+PCW-1:0] prefix_ext;

  always_comb begin
    phase_upd  = phase_r;
    verb_upd   = verb_r;
    stored_upd = stored_r;
    prefix_upd = prefix_r;
    res        = '0;

    case (phase_r)
      tif_pkg::PHASE_CMD: begin
        if (rx_byte == tif_pkg::CODE_WILL || rx_byte == tif_pkg::CODE_WONT ||
            rx_byte == tif_pkg::CODE_DO || rx_byte == tif_pkg::CODE_DONT) begin
          if (rx_byte == tif_pkg::CODE_WILL) begin
            verb_upd = tif_pkg::VERB_WILL;
          end else if (rx_byte == tif_pkg::CODE_DO) begin
            verb_upd = tif_pkg::VERB_DO;
          end else begin
            verb_upd = tif_pkg::VERB_QUIET;
          end
          phase_upd = tif_pkg::PHASE_OPT;
        end else begin
          phase_upd = tif_pkg::PHASE_DATA;
        end
      end
      tif_pkg::PHASE_OPT: begin
        if (verb_r == tif_pkg::VERB_WILL || verb_r == tif_pkg::VERB_DO) begin
          res.neg_valid  = 1'b1;
          res.neg_reply  = (verb_r == tif_pkg::VERB_DO) ? tif_pkg::REPLY_WONT
                                                       : tif_pkg::REPLY_DONT;
          res.neg_option = rx_byte;
        end
        verb_upd  = tif_pkg::VERB_QUIET;
        phase_upd = tif_pkg::PHASE_DATA;
      end
      default: begin
        if (rx_byte == tif_pkg::CODE_IAC) begin
          phase_upd = tif_pkg::PHASE_CMD;
        end else begin
          res.data_byte = rx_byte;
          if (prefix_r < PW'(PREFIX_LEN)) begin
            prefix_upd    = prefix_r + PW'(1);
            res.in_prefix = 1'b1;
          end
          if (stored_r < SW'(BUF_CAPACITY)) begin
            stored_upd     = stored_r + SW'(1);
            res.data_valid = 1'b1;
          end
        end
      end
    endcase

    // counts are reported in their low bits only
    stored_ext       = {{SCW{1'b0}}, stored_upd};
    prefix_ext       = {{PCW{1'b0}}, prefix_upd};
    res.line_done    = end_of_line;
    res.stored_count = end_of_line ? stored_ext[SCW-1:0] : '0;
    res.prefix_count = end_of_line ? prefix_ext[PCW-1:0] : '0;
  end

  always_comb begin
    phase_nxt  = phase_r;
    verb_nxt   = verb_r;
    stored_nxt = stored_r;
    prefix_nxt = prefix_r;
    if (en) begin
      if (end_of_line) begin
        phase_nxt  = tif_pkg::PHASE_DATA;
        verb_nxt   = tif_pkg::VERB_QUIET;
        stored_nxt = '0;
        prefix_nxt = '0;
      end else begin
        phase_nxt  = phase_upd;
        verb_nxt   = verb_upd;
        stored_nxt = stored_upd;
        prefix_nxt = prefix_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= tif_pkg::PHASE_DATA;
      verb_r   <= tif_pkg::VERB_QUIET;
      stored_r <= '0;
      prefix_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      verb_r   <= verb_nxt;
      stored_r <= stored_nxt;
      prefix_r <= prefix_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_verb_only_opt: assert property (@(posedge clk) disable iff (!rst_n)
    (verb_r != tif_pkg::VERB_QUIET) |-> (phase_r == tif_pkg::PHASE_OPT))
    else $error("pending verb outside option phase");

  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (en && end_of_line) |=> (phase_r == tif_pkg::PHASE_DATA && stored_r == '0 &&
                            prefix_r == '0))
    else $error("state not cleared after line end");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (stored_r <= SW'(BUF_CAPACITY)) && (prefix_r <= PW'(PREFIX_LEN)))
    else $error("line counter beyond its limit");
`endif

endmodule

### rtl/telnet_iac_filter.sv
// telnet_iac_filter: top level, input register, parser and result register
// depends on tif_pkg, tif_if (tif_in_if, tif_out_if) and tif_parse
//
//  channel  dir  payload                                   transfer when
//  in_ch    in   rx_byte, end_of_line                      valid && ready
//  out_ch   out  data/neg fields, line_done, both counts   valid && ready
//
// one result per input byte; the byte is held in the input register and its result in the
// result register, from which out_ch transfers it
// a byte can be taken every cycle while out_ch does not stall; the parser state is the
// only loop and it closes between the input register and the result register
// rst_n is synchronous and active low; it empties both registers and clears the parser
// an out stall holds the result register, then the input register; in_ch.ready drops
// only when both are full and out_ch.ready is low
module telnet_iac_filter #(
  parameter int BUF_CAPACITY = tif_pkg::BUF_CAPACITY_DEF,
  parameter int PREFIX_LEN   = tif_pkg::PREFIX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tif_in_if.sink    in_ch,
  tif_out_if.source out_ch
);

  logic          s0_valid_r;
  logic [7:0]    s0_byte_r;
  logic          s0_eol_r;
  logic          out_valid_r;
  tif_pkg::res_t out_res_r;
  tif_pkg::res_t res;
  logic          advance;
  logic          in_xfer;

  // s0 moves into the result register when that register is free or draining
  assign advance      = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s0_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  tif_parse #(
    .BUF_CAPACITY (BUF_CAPACITY),
    .PREFIX_LEN   (PREFIX_LEN)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .rx_byte     (s0_byte_r),
    .end_of_line (s0_eol_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s0_valid_r <= 1'b1;
      end else if (advance) begin
        s0_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_byte_r <= in_ch.rx_byte;
      s0_eol_r  <= in_ch.end_of_line;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_valid   = out_res_r.data_valid;
  assign out_ch.data_byte    = out_res_r.data_byte;
  assign out_ch.in_prefix    = out_res_r.in_prefix;
  assign out_ch.neg_valid    = out_res_r.neg_valid;
  assign out_ch.neg_reply    = out_res_r.neg_reply;
  assign out_ch.neg_option   = out_res_r.neg_option;
  assign out_ch.line_done    = out_res_r.line_done;
  assign out_ch.stored_count = out_res_r.stored_count;
  assign out_ch.prefix_count = out_res_r.prefix_count;

`ifndef ASSERT_OFF
  a_data_or_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.data_valid && out_res_r.neg_valid))
    else $error("result carries both a data byte and a refusal");

  a_counts_on_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.line_done) |->
      (out_res_r.stored_count == '0 && out_res_r.prefix_count == '0))
    else $error("counts reported before line end");

  a_s0_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && !advance) |=> (s0_valid_r && $stable(s0_byte_r) && $stable(s0_eol_r)))
    else $error("stalled input byte lost");
`endif

endmodule

### bench/tb_telnet_iac_filter.sv
// tb_telnet_iac_filter: self-checking bench for the telnet iac filter, one byte per transfer
// depends on tif_pkg, tif_in_if / tif_out_if and telnet_iac_filter from the rtl folder
// a local copy of the parser predicts every result; directed, random, full-buffer and stall tests
module tb_telnet_iac_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          BUF_CAP      = tif_pkg::BUF_CAPACITY_DEF;
  localparam int          PREFIX_MAX   = tif_pkg::PREFIX_LEN_DEF;
  localparam int          RANDOM_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          QUIET_CYCLES = 8;

  logic clk;
  logic rst_n;

  tif_in_if  in_ch ();
  tif_out_if out_ch ();

  telnet_iac_filter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state, one line at a time
  logic [1:0] parse_st;
  logic [1:0] verb_st;
  int         stored_bytes;
  int         prefix_bytes;

  tif_pkg::res_t line_results_q[$];
  int            mismatch_count;
  int            sent_items;
  int unsigned   cycle_count;
  bit            tx_idle_on;
  bit            rx_idle_on;
  int            rx_hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_telnet_iac_filter NOT OK");
    $finish;
  end

  function automatic tif_pkg::res_t filter_byte(input logic [7:0] rx, input logic eol);
    tif_pkg::res_t r;
    r = '0;
    case (parse_st)
      tif_pkg::PHASE_CMD: begin
        if (rx == tif_pkg::CODE_WILL || rx == tif_pkg::CODE_WONT ||
            rx == tif_pkg::CODE_DO || rx == tif_pkg::CODE_DONT) begin
          if (rx == tif_pkg::CODE_WILL)    verb_st = tif_pkg::VERB_WILL;
          else if (rx == tif_pkg::CODE_DO) verb_st = tif_pkg::VERB_DO;
          else                             verb_st = tif_pkg::VERB_QUIET;
          parse_st = tif_pkg::PHASE_OPT;
        end else begin
          parse_st = tif_pkg::PHASE_DATA;
        end
      end
      tif_pkg::PHASE_OPT: begin
        if (verb_st == tif_pkg::VERB_WILL || verb_st == tif_pkg::VERB_DO) begin
          r.neg_valid  = 1'b1;
          r.neg_reply  = (verb_st == tif_pkg::VERB_DO) ? tif_pkg::REPLY_WONT
                                                      : tif_pkg::REPLY_DONT;
          r.neg_option = rx;
        end
        verb_st  = tif_pkg::VERB_QUIET;
        parse_st = tif_pkg::PHASE_DATA;
      end
      default: begin
        if (rx == tif_pkg::CODE_IAC) begin
          parse_st = tif_pkg::PHASE_CMD;
        end else begin
          r.data_byte = rx;
          if (prefix_bytes < PREFIX_MAX) begin
            prefix_bytes++;
            r.in_prefix = 1'b1;
          end
          if (stored_bytes < BUF_CAP) begin
            stored_bytes++;
            r.data_valid = 1'b1;
          end
        end
      end
    endcase
    r.line_done = eol;
    if (eol) begin
      r.stored_count = stored_bytes[tif_pkg::STORED_COUNT_W-1:0];
      r.prefix_count = prefix_bytes[tif_pkg::PREFIX_COUNT_W-1:0];
      parse_st     = tif_pkg::PHASE_DATA;
      verb_st      = tif_pkg::VERB_QUIET;
      stored_bytes = 0;
      prefix_bytes = 0;
    end
    return r;
  endfunction

  // receiver: random stall after each transfer when rx_idle_on is set, plus an optional long hold-off
  initial begin
    int wait_left;
    wait_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        wait_left = rx_idle_on ? $urandom_range(0, 6) : 0;
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string fname, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, fname, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    tif_pkg::res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (line_results_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual data_byte %0d",
                 $time, out_ch.data_byte);
        mismatch_count++;
      end else begin
        want = line_results_q.pop_front();
        check_field("data_valid",   16'(want.data_valid),   16'(out_ch.data_valid));
        check_field("data_byte",    16'(want.data_byte),    16'(out_ch.data_byte));
        check_field("in_prefix",    16'(want.in_prefix),    16'(out_ch.in_prefix));
        check_field("neg_valid",    16'(want.neg_valid),    16'(out_ch.neg_valid));
        check_field("neg_reply",    16'(want.neg_reply),    16'(out_ch.neg_reply));
        check_field("neg_option",   16'(want.neg_option),   16'(out_ch.neg_option));
        check_field("line_done",    16'(want.line_done),    16'(out_ch.line_done));
        check_field("stored_count", 16'(want.stored_count), 16'(out_ch.stored_count));
        check_field("prefix_count", 16'(want.prefix_count), 16'(out_ch.prefix_count));
      end
    end
  end

  // valid stays high across back-to-back bytes; only a gap or wait_all_results lowers it
  task automatic send_byte(input logic [7:0] rx, input logic eol);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.rx_byte     <= rx;
    in_ch.end_of_line <= eol;
    do @(posedge clk); while (!in_ch.ready);
    line_results_q.push_back(filter_byte(rx, eol));
    sent_items++;
  endtask

  task automatic send_line(input logic [7:0] bytes_q[$]);
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (line_results_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_verb();
    case ($urandom_range(0, 3))
      0:       return tif_pkg::CODE_WILL;
      1:       return tif_pkg::CODE_WONT;
      2:       return tif_pkg::CODE_DO;
      default: return tif_pkg::CODE_DONT;
    endcase
  endfunction

  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // plain data, fifth byte falls outside the prefix
    send_line('{8'h00, 8'hFE, 8'h01, 8'h80, 8'h7F});
    // every verb, an unknown command and a doubled iac
    send_line('{tif_pkg::CODE_IAC, tif_pkg::CODE_WILL, 8'h00,
                tif_pkg::CODE_IAC, tif_pkg::CODE_DO, 8'hFF,
                tif_pkg::CODE_IAC, tif_pkg::CODE_WONT, 8'h18,
                tif_pkg::CODE_IAC, tif_pkg::CODE_DONT, 8'h01,
                tif_pkg::CODE_IAC, 8'hF1, tif_pkg::CODE_IAC, tif_pkg::CODE_IAC, 8'h41});
    // commands cut by end of line, then a line that must start clean
    send_line('{tif_pkg::CODE_IAC});
    send_line('{tif_pkg::CODE_IAC, tif_pkg::CODE_WILL});
    send_line('{8'h42});
    // refusal on the very last byte
    send_line('{tif_pkg::CODE_IAC, tif_pkg::CODE_DO, 8'h03});
    wait_all_results();
  endtask

  task automatic test_random_lines();
    logic [7:0] line_q[$];
    int         segs;
    int         stop_at;
    stop_at = sent_items + RANDOM_ITEMS;
    while (sent_items < stop_at) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      line_q.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        segs = $urandom_range(1, 8);
        repeat (segs) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
              repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 254)));
            5, 6, 7: begin
              line_q.push_back(tif_pkg::CODE_IAC);
              line_q.push_back(pick_verb());
              line_q.push_back(8'($urandom_range(0, 255)));
            end
            8: begin
              line_q.push_back(tif_pkg::CODE_IAC);
              line_q.push_back(8'($urandom_range(0, 250)));
            end
            default: begin
              line_q.push_back(tif_pkg::CODE_IAC);
              line_q.push_back(tif_pkg::CODE_IAC);
            end
          endcase
        end
        // broken lines: end of line lands wherever it falls
        if ($urandom_range(0, 4) == 0)
          line_q = line_q[0:$urandom_range(0, line_q.size() - 1)];
      end
      send_line(line_q);
    end
    wait_all_results();
  endtask

  task automatic test_full_buffer();
    logic [7:0] line_q[$];
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    repeat (BUF_CAP + 1) line_q.push_back(8'($urandom_range(0, 254)));
    // negotiation still answered once the buffer is full
    line_q.push_back(tif_pkg::CODE_IAC);
    line_q.push_back(tif_pkg::CODE_WILL);
    line_q.push_back(8'h22);
    repeat (3) line_q.push_back(8'($urandom_range(0, 254)));
    send_line(line_q);
    wait_all_results();
  endtask

  task automatic test_backpressure();
    logic [7:0] line_q[$];
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    rx_hold_left = 120;
    repeat (40) line_q.push_back(8'($urandom_range(0, 255)));
    send_line(line_q);
    // sender waits for every result before the next burst
    wait_all_results();
    line_q.delete();
    repeat (20) line_q.push_back(8'($urandom_range(0, 255)));
    line_q.push_back(tif_pkg::CODE_IAC);
    line_q.push_back(tif_pkg::CODE_DO);
    line_q.push_back(8'h1F);
    send_line(line_q);
    wait_all_results();
  endtask

  initial begin
    parse_st       = tif_pkg::PHASE_DATA;
    verb_st        = tif_pkg::VERB_QUIET;
    stored_bytes   = 0;
    prefix_bytes   = 0;
    mismatch_count = 0;
    sent_items     = 0;
    cycle_count    = 0;
    rx_hold_left   = 0;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.rx_byte     <= 8'h00;
    in_ch.end_of_line <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_lines();
    test_full_buffer();
    test_backpressure();

    if (mismatch_count == 0 && line_results_q.size() == 0)
      $display("tb_telnet_iac_filter OK");
    else
      $display("tb_telnet_iac_filter NOT OK");
    $finish;
  end

endmodule

### sim.f
rtl/tif_pkg.sv
rtl/tif_if.sv
rtl/tif_parse.sv
rtl/telnet_iac_filter.sv
bench/tb_telnet_iac_filter.sv
